// File: sv/tls13_server_hello_parser_assert.svh
// Assertion macros shared by the server hello parser modules.
`ifndef TLS13_SERVER_HELLO_PARSER_ASSERT_SVH
`define TLS13_SERVER_HELLO_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked on every rising clock edge outside reset.
`define SHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/tls13shp_pkg.sv
// Package with types, constants and tables of the server hello parser.
package tls13shp_pkg;

  localparam int unsigned CookieMax = 512;

  localparam logic [15:0] XtVersions = 16'd43;
  localparam logic [15:0] XtKeyshare = 16'd51;
  localparam logic [15:0] XtPsk      = 16'd41;
  localparam logic [15:0] XtCookie   = 16'd44;
  localparam logic [15:0] Tls13Code  = 16'h0304;
  localparam logic [15:0] LegacyVer  = 16'h0303;

  // Configuration register indexes.
  localparam logic [2:0] CfgPskMode   = 3'd0;
  localparam logic [2:0] CfgKeyGroup  = 3'd1;
  localparam logic [2:0] CfgShareLen  = 3'd2;
  localparam logic [2:0] CfgCtLen     = 3'd3;
  localparam logic [2:0] CfgSuiteA    = 3'd4;
  localparam logic [2:0] CfgSuiteB    = 3'd5;

  // Payload kinds.
  localparam logic [1:0] KindNone   = 2'd0;
  localparam logic [1:0] KindPub    = 2'd1;
  localparam logic [1:0] KindCt     = 2'd2;
  localparam logic [1:0] KindCookie = 2'd3;

  typedef enum logic [4:0] {
    PH_VER0, PH_VER1, PH_RAND, PH_SID, PH_SUITE0, PH_SUITE1, PH_COMP,
    PH_XLEN0, PH_XLEN1, PH_ETYPE0, PH_ETYPE1, PH_ELEN0, PH_ELEN1,
    PH_SV0, PH_SV1, PH_KG0, PH_KG1, PH_KL0, PH_KL1, PH_KCT, PH_KPUB,
    PH_PSK0, PH_PSK1, PH_CK0, PH_CK1, PH_CKB
  } phase_e;

  typedef struct packed {
    logic        psk_offer;
    logic [15:0] key_group;
    logic [15:0] share_len;
    logic [11:0] ct_len;
    logic [15:0] suite_a;
    logic [15:0] suite_b;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic        done;
    logic        status;
    logic        retry;
    logic        psk;
    logic        share;
    logic [15:0] group;
    logic [15:0] ck_len;
    logic [3:0]  seen;
  } result_t;

  // Retry-request magic value of the random field.
  function automatic logic [7:0] retry_magic(input logic [4:0] idx);
    logic [7:0] m;
    case (idx)
      5'd0: m = 8'hcf;   5'd1: m = 8'h21;   5'd2: m = 8'had;   5'd3: m = 8'h74;
      5'd4: m = 8'he5;   5'd5: m = 8'h9a;   5'd6: m = 8'h61;   5'd7: m = 8'h11;
      5'd8: m = 8'hbe;   5'd9: m = 8'h1d;   5'd10: m = 8'h8c;  5'd11: m = 8'h02;
      5'd12: m = 8'h1e;  5'd13: m = 8'h65;  5'd14: m = 8'hb8;  5'd15: m = 8'h91;
      5'd16: m = 8'hc2;  5'd17: m = 8'ha2;  5'd18: m = 8'h11;  5'd19: m = 8'h16;
      5'd20: m = 8'h7a;  5'd21: m = 8'hbb;  5'd22: m = 8'h8c;  5'd23: m = 8'h5e;
      5'd24: m = 8'h07;  5'd25: m = 8'h9e;  5'd26: m = 8'h09;  5'd27: m = 8'he2;
      5'd28: m = 8'hc8;  5'd29: m = 8'ha8;  5'd30: m = 8'h33;  default: m = 8'h9c;
    endcase
    return m;
  endfunction

endpackage

// File: sv/tls13_server_hello_parser.sv
// Top level of the TLS 1.3 server hello parser.
// One body byte is accepted per cycle: a byte is parsed by a small state machine between the
// input and a one-entry result register, so the block takes a byte every cycle while the
// result register can move on; results (payload bytes and the verdict on the last byte) appear
// in the cycle after the byte that causes them. Configuration writes are taken at any time.
module tls13_server_hello_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  payload_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        done_res_o,
  output logic        status_o,
  output logic        hello_retry_o,
  output logic        psk_accepted_o,
  output logic        key_share_present_o,
  output logic [15:0] selected_group_o,
  output logic [15:0] cookie_length_o,
  output logic [3:0]  seen_mask_o
);
  import tls13shp_pkg::*;

  cfg_t    cfg;
  result_t res, res_q;
  logic    emit, step, vld_q;

  assign in_ready_o = !vld_q || out_ready_i;
  assign step = in_valid_i && in_ready_o;

  tls13shp_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );

  tls13shp_core u_core (
    .clk_i, .rst_ni, .step_i(step), .byte_i(data_byte_i), .last_i(last_byte_i),
    .cfg_i(cfg), .emit_o(emit), .res_o(res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && emit) res_q <= res;
  end

  assign out_valid_o         = vld_q;
  assign payload_kind_o      = res_q.kind;
  assign payload_byte_o      = res_q.pbyte;
  assign done_res_o          = res_q.done;
  assign status_o            = res_q.status;
  assign hello_retry_o       = res_q.retry;
  assign psk_accepted_o      = res_q.psk;
  assign key_share_present_o = res_q.share;
  assign selected_group_o    = res_q.group;
  assign cookie_length_o     = res_q.ck_len;
  assign seen_mask_o         = res_q.seen;

`include "tls13_server_hello_parser_assert.svh"
  `SHP_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `SHP_ASSERT_IMP(a_stall, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)
  `SHP_ASSERT_NEXT(a_load, clk_i, rst_ni, step && emit, out_valid_o)
endmodule

// File: sv/tls13shp_cfg.sv
// Configuration register file of the server hello parser.
module tls13shp_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output tls13shp_pkg::cfg_t   cfg_o
);
  import tls13shp_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  // Register decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPskMode:  cfg_d.psk_offer = cfg_data_i[0];
        CfgKeyGroup: cfg_d.key_group = cfg_data_i;
        CfgShareLen: cfg_d.share_len = cfg_data_i;
        CfgCtLen:    cfg_d.ct_len    = cfg_data_i[11:0];
        CfgSuiteA:   cfg_d.suite_a   = cfg_data_i;
        CfgSuiteB:   cfg_d.suite_b   = cfg_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{psk_offer: 1'b0, key_group: 16'd29, share_len: 16'd32,
                 ct_len: 12'd0, suite_a: 16'd4867, suite_b: 16'd4867};
    end else begin
      cfg_q <= cfg_d;
    end
  end
endmodule

// File: sv/tls13shp_core.sv
// Per-byte parse state machine of the server hello parser.
module tls13shp_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              byte_i,
  input  logic                    last_i,
  input  tls13shp_pkg::cfg_t      cfg_i,
  output logic                    emit_o,
  output tls13shp_pkg::result_t   res_o
);
  import tls13shp_pkg::*;

  phase_e      ph_q, ph_d;
  logic [15:0] cnt_q, cnt_d, body_q, body_d, ext_q, ext_d, etype_q, etype_d;
  logic [7:0]  acc_q, acc_d;
  logic [3:0]  seen_q, seen_d;
  logic        err_q, err_d, magic_q, magic_d, ver_q, ver_d, psk_q, psk_d;
  logic        share_q, share_d;
  logic [15:0] grp_q, grp_d, ckl_q, ckl_d;
  logic [15:0] w;
  logic [3:0]  xbit;
  logic [1:0]  kind;
  logic        hrr, ok;

  assign w   = {acc_q, byte_i};
  assign hrr = magic_q;

  // Extension type to seen bit.
  always_comb begin
    case (etype_q)
      XtVersions: xbit = 4'b0001;
      XtKeyshare: xbit = 4'b0010;
      XtPsk:      xbit = 4'b0100;
      XtCookie:   xbit = 4'b1000;
      default:    xbit = 4'b0000;
    endcase
  end

  // Next-state logic for one accepted byte.
  always_comb begin
    ph_d = ph_q; cnt_d = cnt_q; body_d = body_q; ext_d = ext_q; etype_d = etype_q;
    acc_d = acc_q; seen_d = seen_q; err_d = err_q; magic_d = magic_q; ver_d = ver_q;
    psk_d = psk_q; share_d = share_q; grp_d = grp_q; ckl_d = ckl_q;
    kind = KindNone;
    if (step_i && !err_q) begin
      if (ph_q >= PH_ETYPE0 && body_q == 16'd0) begin
        err_d = 1'b1;
      end else begin
        if (ph_q >= PH_ETYPE0) body_d = body_q - 16'd1;
        if (ph_q >= PH_SV0) ext_d = ext_q - 16'd1;
        unique case (ph_q)
          PH_VER0, PH_SUITE0, PH_XLEN0, PH_ETYPE0, PH_ELEN0,
          PH_SV0, PH_KG0, PH_KL0, PH_PSK0, PH_CK0: begin
            acc_d = byte_i;
            ph_d = phase_e'(ph_q + 5'd1);
          end
          PH_VER1: begin
            if (w != LegacyVer) err_d = 1'b1;
            else begin cnt_d = '0; ph_d = PH_RAND; end
          end
          PH_RAND: begin
            if (byte_i != retry_magic(cnt_q[4:0])) magic_d = 1'b0;
            cnt_d = cnt_q + 16'd1;
            if (cnt_q[4:0] == 5'd31) ph_d = PH_SID;
          end
          PH_SID: begin
            if (byte_i != 8'd0) err_d = 1'b1; else ph_d = PH_SUITE0;
          end
          PH_SUITE1: begin
            if (w != cfg_i.suite_a && w != cfg_i.suite_b) err_d = 1'b1;
            else ph_d = PH_COMP;
          end
          PH_COMP: begin
            if (byte_i != 8'd0) err_d = 1'b1; else ph_d = PH_XLEN0;
          end
          PH_XLEN1: begin
            body_d = w; ph_d = PH_ETYPE0;
          end
          PH_ETYPE1: begin
            etype_d = w; ph_d = PH_ELEN0;
          end
          PH_ELEN1: begin
            ext_d = w;
            if (w > body_d) err_d = 1'b1;
            else if (etype_q == XtPsk && (hrr || !cfg_i.psk_offer)) err_d = 1'b1;
            else if (xbit == 4'd0 || (seen_q & xbit) != 4'd0) err_d = 1'b1;
            else begin
              seen_d = seen_q | xbit;
              case (etype_q)
                XtVersions: if (w != 16'd2) err_d = 1'b1; else ph_d = PH_SV0;
                XtKeyshare: begin
                  if (hrr || {1'b0, w} != 17'd36 + {5'd0, cfg_i.ct_len}) err_d = 1'b1;
                  else ph_d = PH_KG0;
                end
                XtPsk: if (w != 16'd2) err_d = 1'b1; else ph_d = PH_PSK0;
                default: if (!hrr || w < 16'd2) err_d = 1'b1; else ph_d = PH_CK0;
              endcase
            end
          end
          PH_SV1: begin
            ver_d = (w == Tls13Code); ph_d = PH_ETYPE0;
          end
          PH_KG1: begin
            if (w != cfg_i.key_group) err_d = 1'b1;
            else begin grp_d = w; ph_d = PH_KL0; end
          end
          PH_KL1: begin
            if (w != cfg_i.share_len) err_d = 1'b1;
            else begin
              cnt_d = '0;
              ph_d = (cfg_i.ct_len != 12'd0) ? PH_KCT : PH_KPUB;
            end
          end
          PH_KCT: begin
            kind = KindCt;
            cnt_d = cnt_q + 16'd1;
            if (cnt_d >= {4'd0, cfg_i.ct_len}) begin cnt_d = '0; ph_d = PH_KPUB; end
          end
          PH_KPUB: begin
            kind = KindPub;
            cnt_d = cnt_q + 16'd1;
            if (cnt_d >= 16'd32) begin share_d = 1'b1; ph_d = PH_ETYPE0; end
          end
          PH_PSK1: begin
            if (w == 16'd0) psk_d = 1'b1;
            ph_d = PH_ETYPE0;
          end
          PH_CK1: begin
            ckl_d = w;
            if (w > 16'(CookieMax) || w != ext_d) err_d = 1'b1;
            else ph_d = (w != 16'd0) ? PH_CKB : PH_ETYPE0;
          end
          PH_CKB: begin
            kind = KindCookie;
            if (ext_d == 16'd0) ph_d = PH_ETYPE0;
          end
          default: err_d = 1'b1;
        endcase
      end
    end
  end

  // Result fields for this byte.
  always_comb begin
    ok = !err_d && ver_d && ph_d == PH_ETYPE0 && body_d == 16'd0;
    emit_o = step_i && (kind != KindNone || last_i);
    res_o = '0;
    res_o.kind  = kind;
    res_o.pbyte = (kind != KindNone) ? byte_i : 8'd0;
    if (last_i) begin
      res_o.done   = 1'b1;
      res_o.status = !ok;
      res_o.retry  = magic_d && ph_d > PH_RAND;
      res_o.psk    = psk_d;
      res_o.share  = share_d;
      res_o.group  = share_d ? grp_d : 16'd0;
      res_o.ck_len = ckl_d;
      res_o.seen   = seen_d;
    end
  end

  // State registers; the verdict restarts the parse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_VER0; cnt_q <= '0; body_q <= '0; ext_q <= '0; etype_q <= '0;
      acc_q <= '0; seen_q <= '0; err_q <= 1'b0; magic_q <= 1'b1; ver_q <= 1'b0;
      psk_q <= 1'b0; share_q <= 1'b0; grp_q <= '0; ckl_q <= '0;
    end else if (step_i && last_i) begin
      ph_q <= PH_VER0; cnt_q <= '0; body_q <= '0; ext_q <= '0; etype_q <= '0;
      acc_q <= '0; seen_q <= '0; err_q <= 1'b0; magic_q <= 1'b1; ver_q <= 1'b0;
      psk_q <= 1'b0; share_q <= 1'b0; grp_q <= '0; ckl_q <= '0;
    end else begin
      ph_q <= ph_d; cnt_q <= cnt_d; body_q <= body_d; ext_q <= ext_d;
      etype_q <= etype_d; acc_q <= acc_d; seen_q <= seen_d; err_q <= err_d;
      magic_q <= magic_d; ver_q <= ver_d; psk_q <= psk_d; share_q <= share_d;
      grp_q <= grp_d; ckl_q <= ckl_d;
    end
  end

`include "tls13_server_hello_parser_assert.svh"
  `SHP_ASSERT_IMP(a_err_sticky, clk_i, rst_ni, err_q && !(step_i && last_i), err_d)
  `SHP_ASSERT_IMP(a_kind_no_err, clk_i, rst_ni, kind != KindNone, !err_q && step_i)
  `SHP_ASSERT_NEXT(a_restart, clk_i, rst_ni, step_i && last_i, ph_q == PH_VER0 && !err_q)
endmodule
